@@ src/att_pkg.sv @@
// Package for the allocation tracking table: sizes, codes, word types and
// the expected-release-kind function. No dependencies.
package att_pkg;

  // Table geometry
  localparam int unsigned ENTRIES = 256;
  localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W   = $clog2(ENTRIES + 1);
  localparam int unsigned TOTAL_W = 40;

  // Command codes
  typedef enum logic [1:0] {
    CMD_RECORD  = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_READ    = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_UNKNOWN = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_NULL    = 2'd3
  } status_e;

  // Allocation kinds
  typedef enum logic [2:0] {
    KIND_MALLOC    = 3'd0,
    KIND_CALLOC    = 3'd1,
    KIND_REALLOC   = 3'd2,
    KIND_NEW       = 3'd3,
    KIND_NEW_ARRAY = 3'd4
  } alloc_kind_e;

  // Release kinds
  typedef enum logic [1:0] {
    REL_FREE         = 2'd0,
    REL_DELETE       = 2'd1,
    REL_DELETE_ARRAY = 2'd2
  } rel_kind_e;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_RECORD,
    S_RELEASE,
    S_READ
  } state_e;

  // Command word
  typedef struct packed {
    logic [1:0]  command;
    logic [63:0] address;
    logic [31:0] block_bytes;
    logic [2:0]  alloc_kind;
    logic [1:0]  release_kind;
    logic [15:0] site_file;
    logic [19:0] site_line;
    logic [7:0]  slot_index;
  } att_in_t;

  // Result word
  typedef struct packed {
    logic [1:0]         status;
    logic               kind_mismatch;
    logic [31:0]        found_bytes;
    logic [1:0]         expected_release_kind;
    logic [15:0]        found_site_file;
    logic [19:0]        found_site_line;
    logic [TOTAL_W-1:0] outstanding_bytes;
    logic               slot_used;
    logic [63:0]        slot_address;
    logic [2:0]         slot_alloc_kind;
  } att_out_t;

  // One table slot as held in the RAM
  typedef struct packed {
    logic [63:0] address;
    logic [31:0] bytes;
    logic [15:0] file;
    logic [19:0] line;
    logic [2:0]  kind;
  } entry_t;

  // Release kind that pairs with an allocation kind; unknown kinds expect delete
  function automatic logic [1:0] expected_kind(input logic [2:0] kind);
    logic [1:0] ret;
    case (kind) inside
      KIND_MALLOC, KIND_CALLOC, KIND_REALLOC: ret = REL_FREE;
      KIND_NEW_ARRAY:                         ret = REL_DELETE_ARRAY;
      default:                                ret = REL_DELETE;
    endcase
    return ret;
  endfunction

endpackage

@@ src/allocation_tracking_table.sv @@
// Allocation tracking table: top level with the slot sequencer and byte total.
// Depends on att_pkg and att_ram.
//
//   channel   direction  signals               handshake
//   command   in         start, busy, req_i    taken when start && !busy
//   result    out        done_o, rsp_o         one-cycle strobe, no stall
//
// A record takes the lowest free slot, or answers full; a release scans the
// slots one per cycle through the RAM read port and answers unknown when none
// matches; a read returns the requested slot from the registered read port;
// a null address or an unused command is answered straight from idle. busy is
// high until the strobe rises.
// Reset clears the slot valid bits and the total at once; no clearing pass.
// The receiver cannot stall; the block takes one command at a time.
module allocation_tracking_table (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  att_pkg::att_in_t req_i,
  output logic             done_o,
  output att_pkg::att_out_t rsp_o
);
  import att_pkg::*;

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    scan_q, scan_d;
  logic                pend_q, pend_d;
  logic [IDX_W-1:0]    pidx_q, pidx_d;
  logic [ENTRIES-1:0]  valid_q, valid_d;
  logic [TOTAL_W-1:0]  total_q, total_d;
  logic                done_q, done_d;
  att_in_t             req_q, req_d;
  att_out_t            rsp_q, rsp_d;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  entry_t              ram_wdata;
  logic [IDX_W-1:0]    ram_raddr;
  entry_t              ram_rdata;

  logic [IDX_W-1:0]    scan_idx;
  logic [IDX_W-1:0]    rd_idx;
  logic                rel_hit;
  logic                slot_in_range;
  logic [1:0]          exp_kind;

  assign scan_idx = scan_q[IDX_W-1:0];
  assign rd_idx   = IDX_W'(req_q.slot_index);
  assign exp_kind = expected_kind(ram_rdata.kind);
  assign rel_hit  = pend_q && valid_q[pidx_q] && (ram_rdata.address == req_q.address);
  assign slot_in_range = (32'(req_q.slot_index) < 32'(ENTRIES));

  // Slot storage
  att_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Write word for a record
  always_comb begin
    ram_waddr         = scan_idx;
    ram_wdata.address = req_q.address;
    ram_wdata.bytes   = req_q.block_bytes;
    ram_wdata.file    = req_q.site_file;
    ram_wdata.line    = req_q.site_line;
    ram_wdata.kind    = req_q.alloc_kind;
  end

  // Sequencer: next state, scan control, table and result updates
  always_comb begin
    state_d   = state_q;
    scan_d    = scan_q;
    pend_d    = 1'b0;
    pidx_d    = pidx_q;
    valid_d   = valid_q;
    total_d   = total_q;
    done_d    = 1'b0;
    req_d     = req_q;
    rsp_d     = '0;
    ram_we    = 1'b0;
    ram_raddr = scan_idx;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          req_d  = req_i;
          scan_d = '0;
          unique case (cmd_e'(req_i.command)) inside
            CMD_RECORD, CMD_RELEASE: begin
              if (req_i.address == 64'd0) begin
                rsp_d.status = STAT_NULL;
                done_d       = 1'b1;
              end else if (cmd_e'(req_i.command) == CMD_RECORD) begin
                state_d = S_RECORD;
              end else begin
                state_d = S_RELEASE;
              end
            end
            CMD_READ: begin
              ram_raddr = IDX_W'(req_i.slot_index);
              state_d   = S_READ;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      // One valid bit checked per cycle, lowest free slot wins
      S_RECORD: begin
        if (!valid_q[scan_idx]) begin
          ram_we            = 1'b1;
          valid_d[scan_idx] = 1'b1;
          total_d           = total_q + TOTAL_W'(req_q.block_bytes);
          done_d            = 1'b1;
          state_d           = S_IDLE;
        end else if (scan_q == CNT_W'(ENTRIES - 1)) begin
          rsp_d.status = STAT_FULL;
          done_d       = 1'b1;
          state_d      = S_IDLE;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end

      // Read of slot i overlaps compare of slot i-1
      S_RELEASE: begin
        if (rel_hit) begin
          valid_d[pidx_q]             = 1'b0;
          total_d                     = total_q - TOTAL_W'(ram_rdata.bytes);
          rsp_d.kind_mismatch         = (exp_kind != req_q.release_kind);
          rsp_d.found_bytes           = ram_rdata.bytes;
          rsp_d.expected_release_kind = exp_kind;
          rsp_d.found_site_file       = ram_rdata.file;
          rsp_d.found_site_line       = ram_rdata.line;
          done_d                      = 1'b1;
          state_d                     = S_IDLE;
        end else if (scan_q == CNT_W'(ENTRIES)) begin
          rsp_d.status = STAT_UNKNOWN;
          done_d       = 1'b1;
          state_d      = S_IDLE;
        end else begin
          pend_d = 1'b1;
          pidx_d = scan_idx;
          scan_d = scan_q + 1'b1;
        end
      end

      // RAM data for the requested slot is ready
      S_READ: begin
        ram_raddr = rd_idx;
        if (slot_in_range && valid_q[rd_idx]) begin
          rsp_d.found_bytes           = ram_rdata.bytes;
          rsp_d.expected_release_kind = exp_kind;
          rsp_d.found_site_file       = ram_rdata.file;
          rsp_d.found_site_line       = ram_rdata.line;
          rsp_d.slot_used             = 1'b1;
          rsp_d.slot_address          = ram_rdata.address;
          rsp_d.slot_alloc_kind       = ram_rdata.kind;
        end
        done_d  = 1'b1;
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    rsp_d.outstanding_bytes = total_d;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      scan_q  <= '0;
      pend_q  <= 1'b0;
      pidx_q  <= '0;
      valid_q <= '0;
      total_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      scan_q  <= scan_d;
      pend_q  <= pend_d;
      pidx_q  <= pidx_d;
      valid_q <= valid_d;
      total_q <= total_d;
      done_q  <= done_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    rsp_q <= rsp_d;
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

`ifndef NO_ASSERTIONS
  // Result strobe only once the sequencer is back in idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == S_IDLE))
    else $error("result strobe while sequencer busy");

  // A pending compare exists only during a release scan
  a_pend_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == S_RELEASE))
    else $error("pending compare outside release scan");

  // A record write adds exactly one live slot
  a_record_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> ($countones(valid_q) == $past($countones(valid_q)) + 1))
    else $error("record did not add one live slot");

  // The byte total moves only with a delivered result
  a_total_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (total_q != $past(total_q)) |-> done_q)
    else $error("byte total changed without a result");
`endif

endmodule

@@ src/att_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module att_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ dv/allocation_tracking_table_tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for allocation_tracking_table: directed and random
// record/release/read words, checked against a table model. Uses att_pkg.
module allocation_tracking_table_tb;
  import att_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned RAND_WORDS  = 800;

  logic      clk_i;
  logic      rst_ni = 1'b0;
  logic      start  = 1'b0;
  logic      busy;
  att_in_t   req    = '0;
  logic      done_o;
  att_out_t  rsp_o;

  // Words waiting to be driven, responses owed by the block
  att_in_t   cmd_q[$];
  att_out_t  owed_rsp_q[$];

  // Table model: slots and running byte total
  entry_t             ledger[ENTRIES];
  logic [TOTAL_W-1:0] ledger_total;

  // Generator shadow of live blocks, used only to steer stimulus (addresses, kinds)
  logic [63:0] live_addr[$];
  logic [2:0]  live_kind[$];

  logic took = 1'b0;
  int   gap_left = 0;
  bit   steady = 1'b0;
  int   mismatches = 0;
  int   cycles = 0;
  int   n_words = 0;

  allocation_tracking_table i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Release kind that pairs with a stored allocation kind
  function automatic logic [1:0] release_for(input logic [2:0] kind);
    if (kind <= KIND_REALLOC) return REL_FREE;
    if (kind == KIND_NEW_ARRAY) return REL_DELETE_ARRAY;
    return REL_DELETE;
  endfunction

  // Apply one command to the table model and return the response it owes
  function automatic att_out_t book_command(input att_in_t c);
    att_out_t r;
    int       slot;
    logic [1:0] pair;
    r = '0;
    slot = -1;
    case (c.command)
      CMD_RECORD: begin
        if (c.address == '0) begin
          r.status = STAT_NULL;
        end else begin
          for (int i = 0; i < ENTRIES; i++)
            if (slot < 0 && ledger[i].address == '0) slot = i;
          if (slot < 0) begin
            r.status = STAT_FULL;
          end else begin
            ledger[slot].address = c.address;
            ledger[slot].bytes   = c.block_bytes;
            ledger[slot].file    = c.site_file;
            ledger[slot].line    = c.site_line;
            ledger[slot].kind    = c.alloc_kind;
            ledger_total = ledger_total + c.block_bytes;
          end
        end
      end
      CMD_RELEASE: begin
        if (c.address == '0) begin
          r.status = STAT_NULL;
        end else begin
          for (int i = 0; i < ENTRIES; i++)
            if (slot < 0 && ledger[i].address == c.address) slot = i;
          if (slot < 0) begin
            r.status = STAT_UNKNOWN;
          end else begin
            // a mismatched kind still frees the block
            pair = release_for(ledger[slot].kind);
            ledger[slot].address = '0;
            ledger_total = ledger_total - ledger[slot].bytes;
            r.kind_mismatch         = (pair != c.release_kind);
            r.found_bytes           = ledger[slot].bytes;
            r.expected_release_kind = pair;
            r.found_site_file       = ledger[slot].file;
            r.found_site_line       = ledger[slot].line;
          end
        end
      end
      CMD_READ: begin
        if (c.slot_index < ENTRIES && ledger[c.slot_index].address != '0) begin
          r.found_bytes           = ledger[c.slot_index].bytes;
          r.expected_release_kind = release_for(ledger[c.slot_index].kind);
          r.found_site_file       = ledger[c.slot_index].file;
          r.found_site_line       = ledger[c.slot_index].line;
          r.slot_used             = 1'b1;
          r.slot_address          = ledger[c.slot_index].address;
          r.slot_alloc_kind       = ledger[c.slot_index].kind;
        end
      end
      default: ;
    endcase
    r.outstanding_bytes = ledger_total;
    return r;
  endfunction

  task automatic check_rsp(input att_out_t want, input att_out_t got);
    if (got.status !== want.status || got.kind_mismatch !== want.kind_mismatch ||
        got.found_bytes !== want.found_bytes ||
        got.expected_release_kind !== want.expected_release_kind ||
        got.found_site_file !== want.found_site_file ||
        got.found_site_line !== want.found_site_line ||
        got.outstanding_bytes !== want.outstanding_bytes ||
        got.slot_used !== want.slot_used || got.slot_address !== want.slot_address ||
        got.slot_alloc_kind !== want.slot_alloc_kind) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("rsp mismatch (exp/act): status %0d/%0d mis %0b/%0b bytes %h/%h rk %0d/%0d",
                 want.status, got.status, want.kind_mismatch, got.kind_mismatch,
                 want.found_bytes, got.found_bytes,
                 want.expected_release_kind, got.expected_release_kind);
        $display("  file %h/%h line %h/%h total %h/%h used %0b/%0b addr %h/%h kind %0d/%0d",
                 want.found_site_file, got.found_site_file,
                 want.found_site_line, got.found_site_line,
                 want.outstanding_bytes, got.outstanding_bytes,
                 want.slot_used, got.slot_used, want.slot_address, got.slot_address,
                 want.slot_alloc_kind, got.slot_alloc_kind);
      end
    end
  endtask

  // Word builders for the stimulus; the shadow follows each command
  function automatic att_in_t noise_word();
    logic [159:0] bits;
    att_in_t      w;
    bits = {$urandom, $urandom, $urandom, $urandom, $urandom};
    w = bits[$bits(att_in_t)-1:0];
    return w;
  endfunction

  function automatic logic [63:0] rand_addr();
    logic [63:0] a;
    a = {$urandom, $urandom};
    if (a == '0) a = 64'd1;
    return a;
  endfunction

  function automatic logic [2:0] rand_kind();
    // mostly defined kinds, now and then the undefined ones
    return ($urandom_range(7) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4));
  endfunction

  function automatic logic [1:0] pick_release(input logic [2:0] kind);
    return ($urandom_range(3) != 0) ? release_for(kind) : 2'($urandom_range(3));
  endfunction

  task automatic queue_word(input att_in_t w);
    cmd_q.push_back(w);
    if (w.command != CMD_NONE) n_words++;
  endtask

  // file and line arrive as raw 32-bit draws and are cut to field width here
  task automatic queue_record(input logic [63:0] addr, input logic [2:0] kind,
                              input logic [31:0] bytes, input logic [31:0] file,
                              input logic [31:0] line);
    att_in_t w;
    w = noise_word();
    w.command     = CMD_RECORD;
    w.address     = addr;
    w.alloc_kind  = kind;
    w.block_bytes = bytes;
    w.site_file   = file[15:0];
    w.site_line   = line[19:0];
    queue_word(w);
    if (addr != '0 && live_addr.size() < ENTRIES) begin
      live_addr.push_back(addr);
      live_kind.push_back(kind);
    end
  endtask

  task automatic queue_release(input logic [63:0] addr, input logic [1:0] rkind);
    att_in_t w;
    int      hit;
    w = noise_word();
    w.command      = CMD_RELEASE;
    w.address      = addr;
    w.release_kind = rkind;
    queue_word(w);
    hit = -1;
    foreach (live_addr[j])
      if (hit < 0 && live_addr[j] == addr) hit = j;
    if (addr != '0 && hit >= 0) begin
      live_addr.delete(hit);
      live_kind.delete(hit);
    end
  endtask

  task automatic queue_read(input logic [7:0] idx);
    att_in_t w;
    w = noise_word();
    w.command    = CMD_READ;
    w.slot_index = idx;
    queue_word(w);
  endtask

  task automatic release_some_live();
    int j;
    j = $urandom_range(live_addr.size() - 1);
    queue_release(live_addr[j], pick_release(live_kind[j]));
  endtask

  task automatic record_fresh();
    queue_record(rand_addr(), rand_kind(), $urandom, $urandom, $urandom);
  endtask

  // Driver: hold a word until taken, then idle a drawn number of cycles
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (start && !took) begin
      // still waiting for the block
    end else if (gap_left != 0) begin
      gap_left = gap_left - 1;
      start <= 1'b0;
    end else if (cmd_q.size() != 0) begin
      req   <= cmd_q.pop_front();
      start <= 1'b1;
      if ($urandom_range(31) == 0) steady = !steady;
      gap_left = steady ? 0 : $urandom_range(8);
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: check each strobed response, predict each taken word
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o === 1'b1) begin
        if (owed_rsp_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("response strobed with none owed");
        end else begin
          check_rsp(owed_rsp_q.pop_front(), rsp_o);
        end
      end
      if (start && !busy) owed_rsp_q.push_back(book_command(req));
    end
    took <= rst_ni && start && !busy;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int pick;
    int span;
    foreach (ledger[i]) ledger[i] = '0;
    ledger_total = '0;

    // Directed: field extremes, every command, the corner cases
    queue_record('1, KIND_NEW_ARRAY, '1, '1, '1);
    queue_record(64'd1, KIND_MALLOC, '0, '0, '0);
    queue_record('0, KIND_MALLOC, $urandom, $urandom, $urandom);   // null record
    queue_record(64'd2, 3'd7, $urandom, $urandom, $urandom);       // undefined kind
    queue_record(64'd1, KIND_CALLOC, $urandom, $urandom, $urandom); // duplicate key
    queue_record(64'd3, KIND_REALLOC, $urandom, $urandom, $urandom);
    queue_record(64'd4, KIND_NEW, $urandom, $urandom, $urandom);
    queue_record(64'd5, 3'd5, $urandom, $urandom, $urandom);
    queue_record(64'd6, 3'd6, $urandom, $urandom, $urandom);
    queue_read(8'd0);
    queue_read(8'd3);
    queue_read(8'd255);                                 // never used slot
    queue_release('0, REL_FREE);                        // null release
    queue_release(64'h5555_aaaa_5555_aaaa, REL_FREE);   // unknown key
    queue_release('1, REL_DELETE_ARRAY);
    queue_release(64'd2, 2'd3);                         // meaningless release kind
    queue_release(64'd1, REL_DELETE);                   // wrong kind, still freed
    queue_read(8'd1);
    queue_read(8'd0);
    begin
      att_in_t w;
      w = noise_word();
      w.command = CMD_NONE;
      queue_word(w);
    end
    queue_release(64'd1, REL_FREE);                     // second copy of the key
    queue_release(64'd4, REL_DELETE);
    queue_record(64'd7, KIND_MALLOC, $urandom, $urandom, $urandom);

    // Fill the table, push past full, then drain most of it
    while (live_addr.size() < ENTRIES) record_fresh();
    repeat (4) record_fresh();
    queue_read(8'd255);
    queue_read(8'($urandom_range(255)));
    release_some_live();
    record_fresh();
    record_fresh();
    repeat (200) release_some_live();

    // Mixed traffic over live blocks with some noise
    while (n_words < RAND_WORDS) begin
      pick = $urandom_range(99);
      if (pick < 45 && live_addr.size() < ENTRIES) begin
        if (live_addr.size() != 0 && $urandom_range(7) == 0)
          queue_record(live_addr[$urandom_range(live_addr.size() - 1)], rand_kind(),
                       $urandom, $urandom, $urandom);
        else
          record_fresh();
      end else if (pick < 80 && live_addr.size() != 0) begin
        release_some_live();
      end else if (pick < 94) begin
        span = live_addr.size() + 7;
        if (span > 255 || $urandom_range(3) == 0) span = 255;
        queue_read(8'($urandom_range(span)));
      end else begin
        case ($urandom_range(3))
          0: queue_record('0, rand_kind(), $urandom, $urandom, $urandom);
          1: queue_release('0, 2'($urandom_range(3)));
          2: queue_release(rand_addr(), 2'($urandom_range(3)));
          default: begin
            att_in_t w;
            w = noise_word();
            w.command = CMD_NONE;
            queue_word(w);
          end
        endcase
      end
    end

    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // Wait for everything to be taken and answered, then let a full scan pass
    while (cmd_q.size() != 0 || start || owed_rsp_q.size() != 0) @(negedge clk_i);
    repeat (ENTRIES + 16) @(negedge clk_i);

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
